// ----- hw/rtl/mbps_pkg.sv -----
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked byte pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

	localparam int unsigned MAX_PATTERN_BYTES_DEF = 16;
	localparam int unsigned ADDRESS_BITS_DEF      = 48;

	localparam int unsigned DATA_W     = 8;
	localparam int unsigned FIELD_AW   = 48;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CARE_W     = 16;
	localparam int unsigned PLEN_W     = 5;
	localparam int unsigned PAT_W      = CARE_W * DATA_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW    = 2'd0,
		REG_PATTERN_HIGH   = 2'd1,
		REG_CARE_MASK      = 2'd2,
		REG_PATTERN_LENGTH = 2'd3
	} mbps_reg_t;

	// pattern and care bits as the compare sees them
	typedef struct packed {
		logic [PAT_W-1:0]  pattern;
		logic [CARE_W-1:0] care;
	} mbps_cfg_t;

endpackage : mbps_pkg

`default_nettype wire

// ----- hw/rtl/mbps_if.sv -----
// ----------------------------------------------------------------------------
// mbps_in_if / mbps_out_if
// Valid/ready channels for scanned bytes and match addresses.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbps_in_if
	import mbps_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   data_byte;
	logic [FIELD_AW-1:0] byte_address;
	logic                region_start;

	modport source (output valid, data_byte, byte_address, region_start, input ready);
	modport sink   (input valid, data_byte, byte_address, region_start, output ready);
endinterface : mbps_in_if

interface mbps_out_if
	import mbps_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [FIELD_AW-1:0] match_address;

	modport source (output valid, match_address, input ready);
	modport sink   (input valid, match_address, output ready);
endinterface : mbps_out_if

`default_nettype wire

// ----- hw/rtl/masked_byte_pattern_scan_core.sv -----
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_core
// Byte stream scanner for a masked pattern of up to MAX_PATTERN_BYTES bytes.
// ----------------------------------------------------------------------------
// Takes one byte per clock with its address and a region-start flag; a set
// flag empties the window first, so a match never spans two regions. The
// newest bytes sit in a shift window register; a parallel masked compare
// against the pattern feeds a result register with a matching window's
// first byte address, at most one result per byte. Sustained rate is one
// byte per cycle as long as the result side takes matches; a waiting
// result stalls input only when the window stage also holds a finished
// byte. Pattern length 0 acts as 1, and lengths above MAX_PATTERN_BYTES
// clamp to it. Configuration must be written only while idle, via
// cfg_we/cfg_index/cfg_data; the core itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_scan_core
	import mbps_pkg::*;
#(
	parameter int unsigned MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
	parameter int unsigned ADDRESS_BITS      = ADDRESS_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	mbps_in_if.sink               scan_in,
	mbps_out_if.source            scan_out
);

	localparam int unsigned LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int unsigned AW    = (ADDRESS_BITS < FIELD_AW) ? ADDRESS_BITS : FIELD_AW;

	logic [CFG_DATA_W-1:0] pat_low_q;
	logic [CFG_DATA_W-1:0] pat_high_q;
	logic [CARE_W-1:0]     care_q;
	logic [PLEN_W-1:0]     plen_q;

	logic                  s1_valid_q;
	logic [LEN_W-1:0]      fill_s1;
	logic [DATA_W-1:0]     win_byte_s1 [MAX_PATTERN_BYTES];
	logic [AW-1:0]         win_addr_s1 [MAX_PATTERN_BYTES];

	logic                  out_valid_q;
	logic [FIELD_AW-1:0]   out_addr_q;

	mbps_cfg_t             cfg;
	logic [LEN_W-1:0]      len_eff;
	logic                  hit;
	logic [AW-1:0]         start_addr;
	logic                  s1_adv;
	logic                  in_ready;
	logic                  accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			care_q     <= '0;
			plen_q     <= PLEN_W'(1);
		end else if (cfg_we) begin
			unique case (mbps_reg_t'(cfg_index))
				REG_PATTERN_LOW:    pat_low_q  <= cfg_data;
				REG_PATTERN_HIGH:   pat_high_q <= cfg_data;
				REG_CARE_MASK:      care_q     <= cfg_data[CARE_W-1:0];
				REG_PATTERN_LENGTH: plen_q     <= cfg_data[PLEN_W-1:0];
			endcase
		end
	end

	assign cfg.pattern = {pat_high_q, pat_low_q};
	assign cfg.care    = care_q;

	always_comb begin
		if (plen_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (32'(plen_q) > MAX_PATTERN_BYTES) begin
			len_eff = LEN_W'(MAX_PATTERN_BYTES);
		end else begin
			len_eff = LEN_W'(plen_q);
		end
	end

	// window stage moves on when the result register is free or being drained
	assign s1_adv        = !out_valid_q || scan_out.ready;
	assign in_ready      = !s1_valid_q || s1_adv;
	assign accept        = scan_in.valid && in_ready;
	assign scan_in.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fill_s1    <= '0;
		end else begin
			if (in_ready) begin
				s1_valid_q <= scan_in.valid;
			end
			if (accept) begin
				if (scan_in.region_start) begin
					fill_s1 <= LEN_W'(1);
				end else if (32'(fill_s1) < MAX_PATTERN_BYTES) begin
					fill_s1 <= fill_s1 + LEN_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_byte_s1[0] <= scan_in.data_byte;
			win_addr_s1[0] <= scan_in.byte_address[AW-1:0];
			for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
				win_byte_s1[i] <= win_byte_s1[i-1];
				win_addr_s1[i] <= win_addr_s1[i-1];
			end
		end
	end

	mbps_compare #(
		.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
		.ADDR_W            (AW)
	) u_compare (
		.cfg        (cfg),
		.len_eff    (len_eff),
		.fill       (fill_s1),
		.win_byte   (win_byte_s1),
		.win_addr   (win_addr_s1),
		.hit        (hit),
		.start_addr (start_addr)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid_q && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_q && hit) begin
			out_addr_q <= FIELD_AW'(start_addr);
		end
	end

	assign scan_out.valid         = out_valid_q;
	assign scan_out.match_address = out_addr_q;

endmodule : masked_byte_pattern_scan_core

`default_nettype wire

// ----- hw/rtl/mbps_compare.sv -----
// ----------------------------------------------------------------------------
// mbps_compare
// Parallel masked compare of the byte window against the pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_compare
	import mbps_pkg::*;
#(
	parameter int unsigned MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
	parameter int unsigned ADDR_W            = FIELD_AW
) (
	input  mbps_cfg_t                        cfg,
	input  logic [$clog2(MAX_PATTERN_BYTES+1)-1:0] len_eff,
	input  logic [$clog2(MAX_PATTERN_BYTES+1)-1:0] fill,
	input  logic [DATA_W-1:0]                win_byte [MAX_PATTERN_BYTES],
	input  logic [ADDR_W-1:0]                win_addr [MAX_PATTERN_BYTES],
	output logic                             hit,
	output logic [ADDR_W-1:0]                start_addr
);

	localparam int unsigned LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int unsigned IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

	logic [LEN_W-1:0] last_pos;
	logic [MAX_PATTERN_BYTES-1:0] miss;

	assign last_pos = len_eff - LEN_W'(1);

	// pattern byte j lines up with window entry len-1-j (entry 0 is newest)
	always_comb begin
		logic [LEN_W-1:0] k;
		for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
			k = last_pos - LEN_W'(j);
			miss[j] = 1'b0;
			if (j < CARE_W) begin
				if ((LEN_W'(j) < len_eff) && cfg.care[j] &&
				    (win_byte[k[IDX_W-1:0]] != cfg.pattern[j*DATA_W +: DATA_W])) begin
					miss[j] = 1'b1;
				end
			end
		end
	end

	assign hit        = (fill >= len_eff) && (miss == '0);
	assign start_addr = win_addr[last_pos[IDX_W-1:0]];

endmodule : mbps_compare

`default_nettype wire
